### rtl/rounded_bin_histogram_assert.svh
// Assertion macros for the rounded bin histogram checker.
// Needs nothing else; included by the checker file.
`ifndef ROUNDED_BIN_HISTOGRAM_ASSERT_SVH
`define ROUNDED_BIN_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define RBH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbh assertion failed");

// next-cycle implication
`define RBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbh assertion failed");

`endif

### rtl/rbh_pkg.sv
// Package for the rounded bin histogram: sizes, opcodes, state type and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rbh_pkg;

	localparam int BINS      = 200;
	localparam int DEPTH     = BINS + 1;
	localparam int AW        = $clog2(DEPTH);
	localparam int CNT_W     = 32;
	// bin numerator: BINS * (q + 16384) + 16384, signed
	localparam int NUM_W     = 19 + $clog2(BINS + 1);
	localparam int IDX_W     = NUM_W - 15;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDR,
		ST_RMW
	} rbh_state_t;

	typedef struct packed {
		logic load_in;
		logic calc_addr;
		logic finish;
	} rbh_cmd_t;

	typedef struct packed {
		logic out_free;
	} rbh_stat_t;

endpackage

### rtl/rbh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/rbh_ctrl.sv
// Controller for the rounded bin histogram: accept, address, read-modify-write.
// Uses rbh_pkg.
`timescale 1ns / 1ps

module rbh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rbh_pkg::rbh_stat_t stat,
	output rbh_pkg::rbh_cmd_t  cmd
);

	rbh_pkg::rbh_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			rbh_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = rbh_pkg::ST_ADDR;
				end
			end
			rbh_pkg::ST_ADDR: begin
				cmd.calc_addr = 1'b1;
				state_d       = rbh_pkg::ST_RMW;
			end
			rbh_pkg::ST_RMW: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = rbh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rbh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/rbh_dp.sv
// Datapath for the rounded bin histogram: bin index, counter RAM with valid
// bits, saturating increment, result register. Uses rbh_pkg and rbh_ram.
`timescale 1ns / 1ps

module rbh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rbh_pkg::rbh_cmd_t   cmd,
	output rbh_pkg::rbh_stat_t  stat,
	input  logic [1:0]          opcode,
	input  logic signed [15:0]  sample_value,
	input  logic [7:0]          bin_select,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          bin_number,
	output logic [31:0]         bin_count,
	output logic                in_range
);

	localparam int NW = rbh_pkg::NUM_W;
	localparam int IW = rbh_pkg::IDX_W;
	localparam int AW = rbh_pkg::AW;
	localparam int CW = rbh_pkg::CNT_W;

	logic [1:0]            op_q;
	logic [7:0]            sel_q;
	logic signed [NW-1:0]  num_q;
	logic signed [16:0]    qs;
	logic signed [NW-1:0]  qx;
	logic signed [NW-1:0]  num_d;
	logic [AW-1:0]         addr_q, addr_d;
	logic                  hit_q, hit_d;
	logic [IW-1:0]         idx;
	logic                  add_hit, sel_hit;
	logic [rbh_pkg::DEPTH-1:0] valid_q;
	logic [CW-1:0]         rd_data, cur, inc;
	logic                  wr_en;
	logic                  out_valid_q;
	logic [7:0]            bin_number_q;
	logic [CW-1:0]         bin_count_q;
	logic                  in_range_q;

	// numerator computed at accept
	always_comb begin
		qs    = 17'(sample_value) + 17'sd16384;
		qx    = NW'(qs);
		num_d = qx * NW'(rbh_pkg::BINS) + NW'(32'sd16384);
	end

	// index: negative numerator above -32768 truncates to bin 0
	always_comb begin
		idx     = num_q[NW-1:15];
		add_hit = num_q[NW-1] ? ((&num_q[NW-1:15]) && (|num_q[14:0]))
		                      : ({{(32-IW){1'b0}}, idx} <= 32'(rbh_pkg::BINS));
		sel_hit = {24'd0, sel_q} <= 32'(rbh_pkg::BINS);
		hit_d   = 1'b0;
		addr_d  = '0;
		unique case (op_q)
			rbh_pkg::OP_ADD: begin
				hit_d = add_hit;
				if (add_hit && !num_q[NW-1]) begin
					addr_d = AW'(idx);
				end
			end
			rbh_pkg::OP_READ: begin
				hit_d = sel_hit;
				if (sel_hit) begin
					addr_d = AW'(sel_q);
				end
			end
			default: begin
				hit_d  = 1'b0;
				addr_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= opcode;
			sel_q <= bin_select;
			num_q <= num_d;
		end
		if (cmd.calc_addr) begin
			addr_q <= addr_d;
			hit_q  <= hit_d;
		end
	end

	rbh_ram #(
		.WIDTH(CW),
		.DEPTH(rbh_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_q),
		.wr_data(inc),
		.rd_en  (cmd.calc_addr),
		.rd_addr(addr_d),
		.rd_data(rd_data)
	);

	always_comb begin
		cur   = valid_q[addr_q] ? rd_data : '0;
		inc   = (cur == rbh_pkg::COUNT_MAX) ? cur : cur + CW'(1);
		wr_en = cmd.finish && (op_q == rbh_pkg::OP_ADD) && hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish && (op_q == rbh_pkg::OP_CLEAR)) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			bin_number_q <= '0;
			bin_count_q  <= '0;
			in_range_q   <= 1'b0;
			unique case (op_q)
				rbh_pkg::OP_ADD: begin
					if (hit_q) begin
						bin_number_q <= 8'(addr_q);
						bin_count_q  <= inc;
						in_range_q   <= 1'b1;
					end
				end
				rbh_pkg::OP_READ: begin
					if (hit_q) begin
						bin_number_q <= 8'(addr_q);
						bin_count_q  <= cur;
						in_range_q   <= 1'b1;
					end
				end
				rbh_pkg::OP_CLEAR: begin
					in_range_q <= 1'b1;
				end
				default: begin
					in_range_q <= 1'b0;
				end
			endcase
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign bin_number    = bin_number_q;
	assign bin_count     = bin_count_q;
	assign in_range      = in_range_q;

endmodule

### rtl/rounded_bin_histogram.sv
// Channel  Valid      Stall      Payload
// in       in_valid   in_stall   opcode, sample_value, bin_select
// out      out_valid  out_stall  bin_number, bin_count, in_range
//
// Each item passes through accept with bin numerator multiply, address and
// counter RAM read, then read-modify-write into the result register.
// One item at a time; the counter read-modify-write behind the registered RAM read sets this.
// A full, stalled result register holds the item in its last cycle.
// Reset and the clear opcode zero all counters at once through per-bin valid bits.
// Top level of the rounded bin histogram; uses rbh_pkg, rbh_ctrl, rbh_dp.
`timescale 1ns / 1ps

module rounded_bin_histogram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] sample_value,
	input  logic [7:0]         bin_select,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         bin_number,
	output logic [31:0]        bin_count,
	output logic               in_range
);

	rbh_pkg::rbh_cmd_t  cmd;
	rbh_pkg::rbh_stat_t stat;

	rbh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	rbh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.sample_value(sample_value),
		.bin_select  (bin_select),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bin_number  (bin_number),
		.bin_count   (bin_count),
		.in_range    (in_range)
	);

endmodule

### rtl/rbh_checker.sv
// Port-level checker for the rounded bin histogram, bound to the top level.
// Uses rbh_pkg and rounded_bin_histogram_assert.svh.
`timescale 1ns / 1ps
`include "rounded_bin_histogram_assert.svh"

module rbh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         opcode,
	input logic signed [15:0] sample_value,
	input logic [7:0]         bin_select,
	input logic               out_valid,
	input logic               out_stall,
	input logic [7:0]         bin_number,
	input logic [31:0]        bin_count,
	input logic               in_range
);

	`RBH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(bin_count) && $stable(bin_number) && $stable(in_range))
	`RBH_ASSERT_IMPLY(a_miss_zero, clk, arst_n, out_valid && !in_range, bin_number == 8'd0 && bin_count == 32'd0)
	`RBH_ASSERT_IMPLY(a_bin_bound, clk, arst_n, out_valid, {24'd0, bin_number} <= 32'(rbh_pkg::BINS))
	`RBH_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

bind rounded_bin_histogram rbh_checker u_rbh_checker (.*);

### verif/rbh_checker.sv
// Scoreboard for the rounded bin histogram: it watches both channels, keeps its own bin
// counters and compares each result against the oldest predicted one.
// Needs rbh_pkg.
`timescale 1ns / 1ps

module rbh_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] sample_value,
	input  logic [7:0]         bin_select,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         bin_number,
	input  logic [31:0]        bin_count,
	input  logic               in_range,
	output int                 mismatches,
	output int                 pending
);

	typedef struct packed {
		logic [7:0]                bin;
		logic [rbh_pkg::CNT_W-1:0] count;
		logic                      hit;
	} bin_report_t;

	logic [rbh_pkg::CNT_W-1:0] bin_totals [0:rbh_pkg::BINS];
	bin_report_t               expected_reports [$];
	bin_report_t               want;
	int                        result_no;

	function automatic bin_report_t histogram_update(input logic [1:0] op,
			input logic signed [15:0] q, input logic [7:0] sel);
		bin_report_t r;
		longint      num;
		longint      idx;
		r = '0;
		case (op)
		rbh_pkg::OP_ADD: begin
			// round to nearest bin; division truncates toward zero
			num = longint'(rbh_pkg::BINS) * (longint'(q) + 16384) + 16384;
			idx = num / 32768;
			if (idx >= 0 && idx <= rbh_pkg::BINS) begin
				if (bin_totals[idx] != rbh_pkg::COUNT_MAX)
					bin_totals[idx] = bin_totals[idx] + 1'b1;
				r.bin   = idx[7:0];
				r.count = bin_totals[idx];
				r.hit   = 1'b1;
			end
		end
		rbh_pkg::OP_READ: begin
			if (sel <= rbh_pkg::BINS) begin
				r.bin   = sel;
				r.count = bin_totals[sel];
				r.hit   = 1'b1;
			end
		end
		rbh_pkg::OP_CLEAR: begin
			for (int i = 0; i <= rbh_pkg::BINS; i++)
				bin_totals[i] = '0;
			r.hit = 1'b1;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= rbh_pkg::BINS; i++)
				bin_totals[i] = '0;
			expected_reports.delete();
			mismatches = 0;
			pending    = 0;
			result_no  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %0d: bin %0d count %0d hit %0b",
							$realtime, result_no, bin_number, bin_count, in_range);
				end else begin
					want = expected_reports.pop_front();
					if (bin_number !== want.bin || bin_count !== want.count ||
							in_range !== want.hit) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result %0d: exp bin %0d count %0d hit %0b, ",
								"got bin %0d count %0d hit %0b"},
								$realtime, result_no, want.bin, want.count, want.hit,
								bin_number, bin_count, in_range);
					end
				end
				result_no++;
			end
			if (in_valid && !in_stall)
				expected_reports.push_back(histogram_update(opcode, sample_value, bin_select));
			pending = expected_reports.size();
		end
	end

endmodule

### verif/rounded_bin_histogram_tb.sv
// Testbench top for the rounded bin histogram: clock, reset, sample/read/clear traffic
// with random gaps and stalls, and the verdict.
// Needs rbh_pkg, rbh_scoreboard and the block itself.
`timescale 1ns / 1ps

module rounded_bin_histogram_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         N_ITEMS   = 550;
	// samples from LO_SAMPLE to HI_SAMPLE land in a bin
	localparam int         LO_SAMPLE = -16629;
	localparam int         HI_SAMPLE = 16465;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [15:0] sample_value;
	logic [7:0]         bin_select;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         bin_number;
	logic [31:0]        bin_count;
	logic               in_range;
	int                 mismatches;
	int                 pending;
	int                 items_sent;
	int                 results_taken;
	logic signed [15:0] last_sample;

	rounded_bin_histogram u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample_value (sample_value),
		.bin_select   (bin_select),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bin_number   (bin_number),
		.bin_count    (bin_count),
		.in_range     (in_range)
	);

	rbh_scoreboard u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample_value (sample_value),
		.bin_select   (bin_select),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bin_number   (bin_number),
		.bin_count    (bin_count),
		.in_range     (in_range),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_item(input logic [1:0] op, input logic signed [15:0] q,
			input logic [7:0] sel);
		int gap;
		// every fourth stretch of 40 items goes back to back
		gap = ((items_sent / 40) % 4 == 2) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_value <= q;
		bin_select   <= sel;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (op == rbh_pkg::OP_ADD)
			last_sample = q;
	endtask

	// result side: random stalls, one long hold-off so the block backs up
	initial begin
		int wait_cycles;
		out_stall     <= 1'b0;
		results_taken = 0;
		@(posedge arst_n);
		forever begin
			if (results_taken == 120)
				wait_cycles = 250;
			else if ((results_taken / 40) % 4 == 3)
				wait_cycles = 0;
			else
				wait_cycles = $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	initial begin
		int                 counted;
		int                 pick;
		logic [1:0]         op;
		logic signed [15:0] q;
		logic [7:0]         sel;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		opcode       <= rbh_pkg::OP_ADD;
		sample_value <= '0;
		bin_select   <= '0;
		items_sent   = 0;
		last_sample  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range ends, rounding edges, reads, clear, unused opcode
		send_item(rbh_pkg::OP_CLEAR, 16'sd0, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sh8000, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd32767, 8'hFF);
		send_item(rbh_pkg::OP_ADD, -16'sd16629, 8'd0);
		send_item(rbh_pkg::OP_ADD, -16'sd16630, 8'd0);
		send_item(rbh_pkg::OP_ADD, -16'sd16384, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd0, 8'd0);
		send_item(rbh_pkg::OP_ADD, -16'sd1, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd16384, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd16465, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd16466, 8'd0);
		send_item(rbh_pkg::OP_ADD, 16'sd16465, 8'd0);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd0);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd100);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd200);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd201);
		send_item(rbh_pkg::OP_READ, -16'sd1, 8'd255);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'hAA);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'h55);
		send_item(OP_UNUSED, -16'sd1, 8'hFF);
		send_item(rbh_pkg::OP_CLEAR, -16'sd1, 8'hFF);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd200);
		send_item(rbh_pkg::OP_READ, 16'sd0, 8'd0);

		counted = 0;
		while (counted < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			q    = 16'($urandom);
			sel  = 8'($urandom);
			if (pick < 80) begin
				op = rbh_pkg::OP_ADD;
				if (pick < 16)
					q = last_sample;
				else if (pick < 70)
					q = 16'($urandom_range(HI_SAMPLE - LO_SAMPLE, 0) + LO_SAMPLE);
			end else if (pick < 92) begin
				op = rbh_pkg::OP_READ;
				if (pick < 89)
					sel = 8'($urandom_range(0, rbh_pkg::BINS));
			end else if (pick < 95) begin
				op = rbh_pkg::OP_CLEAR;
			end else begin
				op = OP_UNUSED;
			end
			send_item(op, q, sel);
			counted++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
